// ===== rtl/hrl_pkg.sv =====
package hrl_pkg;

  localparam int SqrtCells = 32;
  localparam int Div1Cells = 17;
  localparam int Div2Cells = 32;

  localparam logic [15:0] THRESHOLD_RST = 16'd256;
  localparam logic [16:0] ONE_Q16       = 17'd65536;

  // One word as it travels down the chain of cells.
  typedef struct packed {
    logic [31:0] e;     // squared error
    logic [15:0] d;     // delta
    logic [31:0] dsq;   // delta squared, Q16.16
    logic        outl;  // outlier flag, valid from the multiply stage on
    logic [31:0] xs;    // radicand bits still to be consumed
    logic [33:0] rem;   // partial remainder (sqrt, then division)
    logic [31:0] root;  // sqrt(e) in Q8.24
    logic [47:0] prod;  // delta * root
    logic [31:0] dvs;   // divisor
    logic [31:0] num;   // dividend bits still to be brought down
    logic [31:0] q;     // quotient
  } hrl_word_t;

endpackage

// ===== rtl/hrl_in_if.sv =====
interface hrl_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] sq_error;

  modport source (output valid, output sq_error, input ready);
  modport sink   (input valid, input sq_error, output ready);
endinterface

// ===== rtl/hrl_out_if.sv =====
interface hrl_out_if;
  logic               valid;
  logic               ready;
  logic        [39:0] loss_value;
  logic        [16:0] first_deriv;
  logic signed [47:0] second_deriv;
  logic               is_outlier;

  modport source (output valid, output loss_value, output first_deriv,
                  output second_deriv, output is_outlier, input ready);
  modport sink   (input valid, input loss_value, input first_deriv,
                  input second_deriv, input is_outlier, output ready);
endinterface

// ===== rtl/hrl_sqrt_cell.sv =====
module hrl_sqrt_cell
  import hrl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  hrl_word_t word_i,
  output logic      valid_o,
  output hrl_word_t word_o
);

  logic      valid_q;
  hrl_word_t word_q, word_d;
  logic [35:0] t, trial;
  logic        ge;

  // One root bit per cell: bring down two radicand bits, try 4*root+1.
  always_comb begin
    t      = {word_i.rem, word_i.xs[31:30]};
    trial  = {2'b00, word_i.root, 2'b01};
    ge     = (t >= trial);
    word_d = word_i;
    word_d.rem  = ge ? 34'(t - trial) : t[33:0];
    word_d.root = {word_i.root[30:0], ge};
    word_d.xs   = {word_i.xs[29:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

// ===== rtl/hrl_div_cell.sv =====
module hrl_div_cell
  import hrl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  hrl_word_t word_i,
  output logic      valid_o,
  output hrl_word_t word_o
);

  logic      valid_q;
  hrl_word_t word_q, word_d;
  logic [32:0] t;
  logic        ge;

  // Restoring division, one quotient bit per cell.
  always_comb begin
    t      = {word_i.rem[31:0], word_i.num[31]};
    ge     = (t >= {1'b0, word_i.dvs});
    word_d = word_i;
    word_d.rem = ge ? 34'(t - {1'b0, word_i.dvs}) : {1'b0, t};
    word_d.q   = {word_i.q[30:0], ge};
    word_d.num = {word_i.num[30:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

// ===== rtl/huber_robust_loss.sv =====
// Huber loss with first and second derivative, one squared residual per word.
//
// in_i  : valid/ready channel carrying sq_error (unsigned Q16.16).
// out_o : valid/ready channel carrying loss_value (Q24.16), first_deriv
//         (Q1.16), second_deriv (signed Q31.16) and is_outlier.
// cfg   : cfg_we_i/cfg_wdata_i write delta (unsigned Q8.8); change it only
//         while the pipeline is empty.
//
// From accept to output valid a word passes through an input register,
// 32 square-root cells, a multiply stage, 17 cells for delta/sqrt(e),
// 32 cells for the second derivative division and the output register.
// One word per cycle unless out_o stalls. The whole chain advances together
// whenever the output register is empty or being taken, so a stalled
// receiver freezes the chain and in_i.ready drops in the same cycle.
// Reset empties the chain and sets delta to 1.0.
module huber_robust_loss
  import hrl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  hrl_in_if.sink      in_i,
  hrl_out_if.source   out_o
);

  localparam int Div2Base = SqrtCells + 1 + Div1Cells;
  localparam int NStages  = Div2Base + Div2Cells;

  logic [15:0] threshold_q;
  logic        en;
  logic        out_valid_q;

  logic      v_s [0:NStages];
  hrl_word_t w_s [0:NStages];

  hrl_word_t in_word_d;
  logic      mul_valid_q;
  hrl_word_t mul_word_q, mul_word_d;
  hrl_word_t div2_in;

  logic        [39:0] loss_q, loss_d;
  logic        [16:0] first_q, first_d;
  logic signed [47:0] second_q, second_d;
  logic               outl_q;
  logic        [47:0] loss_full;

  assign en        = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESHOLD_RST;
    end else if (cfg_we_i) begin
      threshold_q <= cfg_wdata_i;
    end
  end

  // Input register, also the starting state of the root extraction.
  always_comb begin
    in_word_d     = '0;
    in_word_d.e   = in_i.sq_error;
    in_word_d.xs  = in_i.sq_error;
    in_word_d.d   = threshold_q;
    in_word_d.dsq = 32'(threshold_q) * 32'(threshold_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_s[0] <= 1'b0;
    end else if (en) begin
      v_s[0] <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      w_s[0] <= in_word_d;
    end
  end

  for (genvar i = 0; i < SqrtCells; i++) begin : g_sqrt
    hrl_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (v_s[i]),
      .word_i  (w_s[i]),
      .valid_o (v_s[i+1]),
      .word_o  (w_s[i+1])
    );
  end

  // Multiply stage: delta*root for the loss, outlier compare, divider setup.
  always_comb begin
    mul_word_d      = w_s[SqrtCells];
    mul_word_d.prod = 48'(w_s[SqrtCells].d * w_s[SqrtCells].root);
    mul_word_d.outl = (w_s[SqrtCells].e > w_s[SqrtCells].dsq);
    mul_word_d.dvs  = w_s[SqrtCells].root;
    mul_word_d.rem  = {3'b000, w_s[SqrtCells].d, 15'd0};
    mul_word_d.num  = '0;
    mul_word_d.q    = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
    end else if (en) begin
      mul_valid_q <= v_s[SqrtCells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mul_word_q <= mul_word_d;
    end
  end

  assign v_s[SqrtCells + 1] = mul_valid_q;
  assign w_s[SqrtCells + 1] = mul_word_q;

  for (genvar i = SqrtCells + 1; i < Div2Base; i++) begin : g_div1
    hrl_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (v_s[i]),
      .word_i  (w_s[i]),
      .valid_o (v_s[i+1]),
      .word_o  (w_s[i+1])
    );
  end

  // Second division: (first << 15) / e.
  always_comb begin
    div2_in     = w_s[Div2Base];
    div2_in.dvs = w_s[Div2Base].e;
    div2_in.num = {w_s[Div2Base].q[16:0], 15'd0};
    div2_in.rem = '0;
    div2_in.q   = '0;
    div2_in.root = {15'd0, w_s[Div2Base].q[16:0]};  // keeps first_deriv
  end

  for (genvar i = Div2Base; i < NStages; i++) begin : g_div2
    hrl_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (v_s[i]),
      .word_i  ((i == Div2Base) ? div2_in : w_s[i]),
      .valid_o (v_s[i+1]),
      .word_o  (w_s[i+1])
    );
  end

  always_comb begin
    loss_full = (w_s[NStages].prod >> 15) - {16'd0, w_s[NStages].dsq};
    if (w_s[NStages].outl) begin
      loss_d   = loss_full[39:0];
      first_d  = w_s[NStages].root[16:0];
      second_d = -$signed({16'd0, w_s[NStages].q});
    end else begin
      loss_d   = {8'd0, w_s[NStages].e};
      first_d  = ONE_Q16;
      second_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v_s[NStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      loss_q   <= loss_d;
      first_q  <= first_d;
      second_q <= second_d;
      outl_q   <= w_s[NStages].outl;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.loss_value   = loss_q;
  assign out_o.first_deriv  = first_q;
  assign out_o.second_deriv = second_q;
  assign out_o.is_outlier   = outl_q;

  a_inlier_fixed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !outl_q |-> first_q == ONE_Q16 && second_q == '0)
    else $error("inlier word with non-unit derivatives");

  a_second_nonpos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> second_q[47] || second_q == '0)
    else $error("positive second derivative");

  a_first_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && outl_q |-> first_q <= ONE_Q16)
    else $error("first derivative above one for an outlier");

  a_chain_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> v_s[NStages] == $past(v_s[NStages]))
    else $error("chain moved while output stalled");

endmodule
